// ===== src/sfd_pkg.sv =====
// shared types, constants and rounding helper for the stereo flanger delay
`default_nettype none

package sfd_pkg;

  // defaults for the top level parameters
  localparam int unsigned LINE_DEPTH_DEF  = 1024;
  localparam int unsigned SAMPLE_RATE_DEF = 48000;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_TARGET  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TARGET = 4'd1;
  localparam logic [CFG_W-1:0] RATE_TARGET_RST  = 16'd13107;
  localparam logic [CFG_W-1:0] DEPTH_TARGET_RST = 16'd26214;

  // smoothed knob reset values, Q0.24
  localparam logic [23:0] RATE_SMOOTH_RST  = 24'd3355443;
  localparam logic [23:0] DEPTH_SMOOTH_RST = 24'd6710886;

  // arithmetic constants
  localparam int SMOOTH_K    = 25166;
  localparam int HZ_BASE     = 671089;
  localparam int HZ_SLOPE    = 30198989;
  localparam int RIGHT_OFS_K = 3019899;
  localparam int FEEDBACK_K  = 10401874;
  localparam int MIX_K       = 12079596;
  localparam int CENTER      = 170;
  localparam int CENTER_Q8   = 170 * 256;

  // phase increment divider: reciprocal scale
  localparam int unsigned DIV_SH = 26;

  // product width used by the rounding helper
  localparam int unsigned PW = 68;

  // odd sine polynomial, Q.30, lowest order first
  localparam logic signed [32:0] SINE_COEF [5] = '{
    33'sd1686629713, -33'sd693598668, 33'sd85569306, -33'sd5026995, 33'sd172272
  };

  typedef enum logic [1:0] {
    T_IDLE,
    T_PRM,
    T_LANE
  } sfd_top_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_SMR,
    C_SMD,
    C_R2,
    C_HZ,
    C_DIVQ,
    C_DIVR,
    C_OFS,
    C_FB
  } sfd_prm_e;

  typedef enum logic [3:0] {
    L_CLEAR,
    L_IDLE,
    L_X2,
    L_HORN,
    L_PX,
    L_DLY,
    L_RD0,
    L_RD1,
    L_RD2,
    L_INT,
    L_FB,
    L_MIX,
    L_DONE
  } sfd_lane_e;

  // per-frame parameters from the parameter stage
  typedef struct packed {
    logic        done;
    logic [23:0] phase_l;
    logic [23:0] phase_r;
    logic [23:0] depth;
    logic [23:0] fb;
  } sfd_prm_t;

  // command to one lane
  typedef struct packed {
    logic        start;
    logic        ack;
    logic [23:0] phase;
    logic [23:0] depth;
    logic [23:0] fb;
  } sfd_lane_cmd_t;

  // lane status
  typedef struct packed {
    logic ready;
    logic done;
  } sfd_lane_stat_t;

  // arithmetic right shift, round to nearest, ties away from zero
  function automatic logic signed [PW-1:0] rnd_shr(input logic signed [PW-1:0] v,
                                                   input int unsigned s);
    logic signed [PW-1:0] h;
    h = $signed({{(PW-1){1'b0}}, 1'b1}) <<< (s - 32'd1);
    if (v[PW-1]) begin
      rnd_shr = (v + h - $signed({{(PW-1){1'b0}}, 1'b1})) >>> s;
    end else begin
      rnd_shr = (v + h) >>> s;
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/sfd_if.sv =====
// stream interfaces for the input and output stereo frames
`default_nettype none

interface sfd_in_if #(
  parameter int unsigned SW = sfd_pkg::SAMPLE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] in_left;
  logic signed [SW-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface sfd_out_if #(
  parameter int unsigned SW = sfd_pkg::SAMPLE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] out_left;
  logic signed [SW-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

// ===== src/sfd_prm.sv =====
// parameter stage: knob smoothing, lfo rate, phase advance, offset and feedback
`default_nettype none

module sfd_prm #(
  parameter int unsigned SAMPLE_RATE = sfd_pkg::SAMPLE_RATE_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [sfd_pkg::CFG_W-1:0]     rate_tgt_i,
  input  wire  [sfd_pkg::CFG_W-1:0]     depth_tgt_i,
  output sfd_pkg::sfd_prm_t             prm_o
);

  localparam int unsigned DIV_M   = (1 << sfd_pkg::DIV_SH) / SAMPLE_RATE;
  localparam int unsigned SR_HALF = SAMPLE_RATE / 2;
  localparam int unsigned PW      = sfd_pkg::PW;

  sfd_pkg::sfd_prm_e step_q, step_d;
  logic        done_q, done_d;
  logic [23:0] rs_q, rs_d, ds_q, ds_d, ph_q, ph_d;
  logic [24:0] r2_q, r2_d;
  logic [25:0] n_q, n_d, qe_q, qe_d;
  logic [23:0] ofs_q, ofs_d, fb_q, fb_d;

  logic signed [27:0]   op_a, op_b;
  logic signed [55:0]   prod;
  logic signed [PW-1:0] r24;
  logic signed [27:0]   rem;
  logic [25:0]          inc;

  // shared multiplier with rounding
  assign prod = op_a * op_b;
  assign r24  = sfd_pkg::rnd_shr(PW'(prod), 24);

  // sequencer
  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    rs_d   = rs_q;
    ds_d   = ds_q;
    ph_d   = ph_q;
    r2_d   = r2_q;
    n_d    = n_q;
    qe_d   = qe_q;
    ofs_d  = ofs_q;
    fb_d   = fb_q;
    op_a   = '0;
    op_b   = '0;
    rem    = '0;
    inc    = qe_q;
    unique case (step_q)
      sfd_pkg::C_IDLE: begin
        if (start_i) begin
          step_d = sfd_pkg::C_SMR;
        end
      end
      sfd_pkg::C_SMR: begin
        op_a   = $signed({2'b0, rate_tgt_i, 8'b0}) - $signed({4'b0, rs_q});
        op_b   = 28'(sfd_pkg::SMOOTH_K);
        rs_d   = 24'($signed({4'b0, rs_q}) + 28'(r24));
        step_d = sfd_pkg::C_SMD;
      end
      sfd_pkg::C_SMD: begin
        op_a   = $signed({2'b0, depth_tgt_i, 8'b0}) - $signed({4'b0, ds_q});
        op_b   = 28'(sfd_pkg::SMOOTH_K);
        ds_d   = 24'($signed({4'b0, ds_q}) + 28'(r24));
        step_d = sfd_pkg::C_R2;
      end
      sfd_pkg::C_R2: begin
        op_a   = $signed({4'b0, rs_q});
        op_b   = $signed({4'b0, rs_q});
        r2_d   = 25'(r24);
        step_d = sfd_pkg::C_HZ;
      end
      sfd_pkg::C_HZ: begin
        op_a   = $signed({3'b0, r2_q});
        op_b   = 28'(sfd_pkg::HZ_SLOPE);
        n_d    = 26'(r24) + 26'(sfd_pkg::HZ_BASE) + 26'(SR_HALF);
        step_d = sfd_pkg::C_DIVQ;
      end
      sfd_pkg::C_DIVQ: begin
        op_a   = $signed({2'b0, n_q});
        op_b   = 28'(DIV_M);
        qe_d   = 26'(prod >>> sfd_pkg::DIV_SH);
        step_d = sfd_pkg::C_DIVR;
      end
      sfd_pkg::C_DIVR: begin
        // estimate is at most one short: one compare corrects it
        op_a = $signed({2'b0, qe_q});
        op_b = 28'(SAMPLE_RATE);
        rem  = $signed({2'b0, n_q}) - 28'(prod);
        if (rem >= 28'(SAMPLE_RATE)) begin
          inc = qe_q + 26'd1;
        end
        ph_d   = ph_q + 24'(inc);
        step_d = sfd_pkg::C_OFS;
      end
      sfd_pkg::C_OFS: begin
        op_a   = $signed({4'b0, ds_q});
        op_b   = 28'(sfd_pkg::RIGHT_OFS_K);
        ofs_d  = 24'(r24);
        step_d = sfd_pkg::C_FB;
      end
      sfd_pkg::C_FB: begin
        op_a   = $signed({4'b0, ds_q});
        op_b   = 28'(sfd_pkg::FEEDBACK_K);
        fb_d   = 24'(r24);
        done_d = 1'b1;
        step_d = sfd_pkg::C_IDLE;
      end
      default: begin
        step_d = sfd_pkg::C_IDLE;
      end
    endcase
  end

  // state and knob registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sfd_pkg::C_IDLE;
      done_q <= 1'b0;
      rs_q   <= sfd_pkg::RATE_SMOOTH_RST;
      ds_q   <= sfd_pkg::DEPTH_SMOOTH_RST;
      ph_q   <= '0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
      rs_q   <= rs_d;
      ds_q   <= ds_d;
      ph_q   <= ph_d;
    end
  end

  // intermediate results
  always_ff @(posedge clk_i) begin
    r2_q  <= r2_d;
    n_q   <= n_d;
    qe_q  <= qe_d;
    ofs_q <= ofs_d;
    fb_q  <= fb_d;
  end

  assign prm_o.done    = done_q;
  assign prm_o.phase_l = ph_q;
  assign prm_o.phase_r = ph_q + ofs_q;
  assign prm_o.depth   = ds_q;
  assign prm_o.fb      = fb_q;

endmodule

`default_nettype wire

// ===== src/sfd_lane.sv =====
// one channel lane: sine lfo, delay line, interpolation, feedback and mix
`default_nettype none

module sfd_lane #(
  parameter int unsigned LINE_DEPTH  = sfd_pkg::LINE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  sfd_pkg::sfd_lane_cmd_t            cmd_i,
  input  wire  [$clog2(LINE_DEPTH)-1:0]     wp_i,
  input  wire  signed [SAMPLE_BITS-1:0]     in_smp_i,
  output logic signed [SAMPLE_BITS-1:0]     out_smp_o,
  output sfd_pkg::sfd_lane_stat_t           stat_o
);

  localparam int unsigned AW    = $clog2(LINE_DEPTH);
  localparam int unsigned SW    = SAMPLE_BITS;
  localparam int unsigned PW    = sfd_pkg::PW;
  localparam int unsigned TOTAL = LINE_DEPTH * 256;
  localparam longint SMP_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMP_LO = -SMP_HI - 1;

  function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] v);
    if (v > PW'(SMP_HI)) begin
      sat = SW'(SMP_HI);
    end else if (v < PW'(SMP_LO)) begin
      sat = SW'(SMP_LO);
    end else begin
      sat = v[SW-1:0];
    end
  endfunction

  sfd_pkg::sfd_lane_e step_q, step_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [30:0]          x_q, x_d, x2_q, x2_d;
  logic [1:0]           quad_q, quad_d;
  logic signed [32:0]   p_q, p_d;
  logic [2:0]           k_q, k_d;
  logic signed [24:0]   lfo_q, lfo_d;
  logic [32:0]          span_q, span_d;
  logic [23:0]          fb_q, fb_d;
  logic [AW-1:0]        i0_q, i0_d;
  logic [7:0]           frac_q, frac_d;
  logic signed [SW-1:0] b0_q, b0_d, b1_q, b1_d, dry_q, dry_d, wet_q, wet_d, out_q, out_d;

  logic [SW-1:0]        mem [LINE_DEPTH];
  logic [SW-1:0]        rd_q;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [SW-1:0]        wdata;

  logic signed [33:0]   op_a, op_b;
  logic signed [67:0]   prod;

  // lane multiplier
  assign prod = op_a * op_b;

  // sequencer and datapath
  always_comb begin
    logic [22:0]            fz;
    logic signed [PW-1:0]   t30, s7;
    logic signed [19:0]     delay;
    logic signed [AW+9:0]   pos;
    logic [AW:0]            dry_idx;
    step_d = step_q;
    clr_d  = clr_q;
    x_d    = x_q;
    x2_d   = x2_q;
    quad_d = quad_q;
    p_d    = p_q;
    k_d    = k_q;
    lfo_d  = lfo_q;
    span_d = span_q;
    fb_d   = fb_q;
    i0_d   = i0_q;
    frac_d = frac_q;
    b0_d   = b0_q;
    b1_d   = b1_q;
    dry_d  = dry_q;
    wet_d  = wet_q;
    out_d  = out_q;
    op_a   = '0;
    op_b   = '0;
    we     = 1'b0;
    waddr  = wp_i;
    wdata  = '0;
    raddr  = i0_q;
    fz     = '0;
    t30    = '0;
    s7     = '0;
    delay  = '0;
    pos    = '0;
    dry_idx = (wp_i >= AW'(sfd_pkg::CENTER)) ?
              ({1'b0, wp_i} - (AW+1)'(sfd_pkg::CENTER)) :
              ({1'b0, wp_i} + (AW+1)'(LINE_DEPTH - sfd_pkg::CENTER));
    unique case (step_q)
      sfd_pkg::L_CLEAR: begin
        // zero the delay line one entry a cycle
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(LINE_DEPTH - 1)) begin
          step_d = sfd_pkg::L_IDLE;
        end
      end
      sfd_pkg::L_IDLE: begin
        if (cmd_i.start) begin
          // fold phase to a quarter wave
          fz = {1'b0, cmd_i.phase[21:0]};
          if (cmd_i.phase[22]) begin
            fz = 23'h400000 - fz;
          end
          x_d    = {fz, 8'b0};
          quad_d = cmd_i.phase[23:22];
          span_d = {2'b0, cmd_i.depth, 7'b0} + {5'b0, cmd_i.depth, 4'b0}
                 + {9'b0, cmd_i.depth};
          fb_d   = cmd_i.fb;
          step_d = sfd_pkg::L_X2;
        end
      end
      sfd_pkg::L_X2: begin
        op_a   = $signed({3'b0, x_q});
        op_b   = $signed({3'b0, x_q});
        x2_d   = 31'(sfd_pkg::rnd_shr(PW'(prod), 30));
        p_d    = sfd_pkg::SINE_COEF[4];
        k_d    = 3'd3;
        step_d = sfd_pkg::L_HORN;
      end
      sfd_pkg::L_HORN: begin
        op_a = 34'(p_q);
        op_b = $signed({3'b0, x2_q});
        p_d  = sfd_pkg::SINE_COEF[k_q] + 33'(sfd_pkg::rnd_shr(PW'(prod), 30));
        if (k_q == 3'd0) begin
          step_d = sfd_pkg::L_PX;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      sfd_pkg::L_PX: begin
        op_a = 34'(p_q);
        op_b = $signed({3'b0, x_q});
        t30  = sfd_pkg::rnd_shr(PW'(prod), 30);
        s7   = sfd_pkg::rnd_shr(t30, 7);
        if (s7 > PW'(1 << 23)) begin
          s7 = PW'(1 << 23);
        end
        lfo_d  = quad_q[1] ? -25'(s7) : 25'(s7);
        step_d = sfd_pkg::L_DLY;
      end
      sfd_pkg::L_DLY: begin
        // read position behind the write pointer, Q.8
        op_a  = $signed({1'b0, span_q});
        op_b  = 34'(lfo_q);
        delay = 20'(sfd_pkg::CENTER_Q8) + 20'(sfd_pkg::rnd_shr(PW'(prod), 39));
        pos   = $signed({2'b0, wp_i, 8'b0}) - (AW+10)'(delay);
        if (pos[AW+9]) begin
          pos = pos + (AW+10)'(TOTAL);
        end
        i0_d   = pos[AW+7:8];
        frac_d = pos[7:0];
        step_d = sfd_pkg::L_RD0;
      end
      sfd_pkg::L_RD0: begin
        raddr  = i0_q;
        step_d = sfd_pkg::L_RD1;
      end
      sfd_pkg::L_RD1: begin
        raddr  = (i0_q == AW'(LINE_DEPTH - 1)) ? '0 : i0_q + 1'b1;
        b0_d   = rd_q;
        step_d = sfd_pkg::L_RD2;
      end
      sfd_pkg::L_RD2: begin
        raddr  = dry_idx[AW-1:0];
        b1_d   = rd_q;
        step_d = sfd_pkg::L_INT;
      end
      sfd_pkg::L_INT: begin
        // linear interpolation between neighbours
        dry_d  = rd_q;
        op_a   = 34'(b1_q) - 34'(b0_q);
        op_b   = $signed({26'b0, frac_q});
        wet_d  = sat(PW'(b0_q) + sfd_pkg::rnd_shr(PW'(prod), 8));
        step_d = sfd_pkg::L_FB;
      end
      sfd_pkg::L_FB: begin
        // feedback write into the line
        op_a   = 34'(wet_q);
        op_b   = $signed({10'b0, fb_q});
        we     = 1'b1;
        waddr  = wp_i;
        wdata  = sat(PW'(in_smp_i) + sfd_pkg::rnd_shr(PW'(prod), 24));
        step_d = sfd_pkg::L_MIX;
      end
      sfd_pkg::L_MIX: begin
        op_a   = 34'(dry_q) + 34'(wet_q);
        op_b   = 34'(sfd_pkg::MIX_K);
        out_d  = sat(sfd_pkg::rnd_shr(PW'(prod), 24));
        step_d = sfd_pkg::L_DONE;
      end
      sfd_pkg::L_DONE: begin
        if (cmd_i.ack) begin
          step_d = sfd_pkg::L_IDLE;
        end
      end
      default: begin
        step_d = sfd_pkg::L_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sfd_pkg::L_CLEAR;
      clr_q  <= '0;
    end else begin
      step_q <= step_d;
      clr_q  <= clr_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    x2_q   <= x2_d;
    quad_q <= quad_d;
    p_q    <= p_d;
    k_q    <= k_d;
    lfo_q  <= lfo_d;
    span_q <= span_d;
    fb_q   <= fb_d;
    i0_q   <= i0_d;
    frac_q <= frac_d;
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    dry_q  <= dry_d;
    wet_q  <= wet_d;
    out_q  <= out_d;
  end

  // delay line memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign out_smp_o    = out_q;
  assign stat_o.ready = (step_q == sfd_pkg::L_IDLE);
  assign stat_o.done  = (step_q == sfd_pkg::L_DONE);

endmodule

`default_nettype wire

// ===== src/stereo_flanger_delay_core.sv =====
// top level of the stereo flanger delay with feedback
`default_nettype none

// One stereo frame in, one stereo frame out. After a request is accepted, the
// frame passes 8 steps of the parameter stage multiplier (smoothing, lfo
// rate, phase increment, right offset, feedback gain); the parameters are then
// registered and handed to the lanes. Then come 13 steps of each lane's
// multiplier and delay line port, with the two lanes running side by side.
// Last, the lane results are merged into the output register. The next
// request is taken from the cycle after the merge. One frame is in work at a
// time. A finished result waits in the output register while the next frame
// is taken. A frame whose result finds that register still full holds in its
// lanes until the register is read. After reset both delay lines are cleared,
// one entry per cycle, and no request is accepted until the clear is done;
// configuration writes are taken at any time.
module stereo_flanger_delay_core #(
  parameter int unsigned LINE_DEPTH  = sfd_pkg::LINE_DEPTH_DEF,
  parameter int unsigned SAMPLE_RATE = sfd_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  sfd_in_if.sink                           in_i,
  sfd_out_if.source                        out_o,
  input  wire                              cfg_we_i,
  input  wire  [sfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [sfd_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned SW = SAMPLE_BITS;

  sfd_pkg::sfd_top_e state_q, state_d;
  logic [sfd_pkg::CFG_W-1:0] rate_tgt_q, depth_tgt_q;
  logic [AW-1:0]        wp_q, wp_d;
  logic signed [SW-1:0] in_l_q, in_r_q;
  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_l_q, out_r_q;

  logic                    accept, load;
  sfd_pkg::sfd_prm_t       prm;
  sfd_pkg::sfd_lane_cmd_t  cmd_l, cmd_r;
  sfd_pkg::sfd_lane_stat_t stat_l, stat_r;
  logic signed [SW-1:0]    res_l, res_r;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_tgt_q  <= sfd_pkg::RATE_TARGET_RST;
      depth_tgt_q <= sfd_pkg::DEPTH_TARGET_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sfd_pkg::REG_RATE_TARGET) begin
        rate_tgt_q <= cfg_data_i;
      end
      if (cfg_idx_i == sfd_pkg::REG_DEPTH_TARGET) begin
        depth_tgt_q <= cfg_data_i;
      end
    end
  end

  assign in_i.ready = (state_q == sfd_pkg::T_IDLE) && stat_l.ready && stat_r.ready;
  assign accept     = in_i.valid && in_i.ready;

  // frame sequencing
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    load        = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      sfd_pkg::T_IDLE: begin
        if (accept) begin
          state_d = sfd_pkg::T_PRM;
        end
      end
      sfd_pkg::T_PRM: begin
        if (prm.done) begin
          state_d = sfd_pkg::T_LANE;
        end
      end
      sfd_pkg::T_LANE: begin
        if (stat_l.done && stat_r.done && (!out_valid_q || out_o.ready)) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          wp_d        = (wp_q == AW'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          state_d     = sfd_pkg::T_IDLE;
        end
      end
      default: begin
        state_d = sfd_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfd_pkg::T_IDLE;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input hold and merged output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_l_q <= in_i.in_left;
      in_r_q <= in_i.in_right;
    end
    if (load) begin
      out_l_q <= res_l;
      out_r_q <= res_r;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.out_right = out_r_q;

  sfd_prm #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_prm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .rate_tgt_i  (rate_tgt_q),
    .depth_tgt_i (depth_tgt_q),
    .prm_o       (prm)
  );

  // lane commands
  assign cmd_l.start = prm.done;
  assign cmd_l.ack   = load;
  assign cmd_l.phase = prm.phase_l;
  assign cmd_l.depth = prm.depth;
  assign cmd_l.fb    = prm.fb;
  assign cmd_r.start = prm.done;
  assign cmd_r.ack   = load;
  assign cmd_r.phase = prm.phase_r;
  assign cmd_r.depth = prm.depth;
  assign cmd_r.fb    = prm.fb;

  sfd_lane #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_l (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_l),
    .wp_i      (wp_q),
    .in_smp_i  (in_l_q),
    .out_smp_o (res_l),
    .stat_o    (stat_l)
  );

  sfd_lane #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_r (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_r),
    .wp_i      (wp_q),
    .in_smp_i  (in_r_q),
    .out_smp_o (res_r),
    .stat_o    (stat_r)
  );

`ifndef SYNTHESIS
  // the two lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_l.done == stat_r.done) && (stat_l.ready == stat_r.ready))
    else $error("lanes out of step");

  // a lane only finishes while a frame is in the lanes
  a_done_in_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_l.done |-> (state_q == sfd_pkg::T_LANE))
    else $error("lane done outside lane phase");

  // an accepted request starts the parameter stage
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == sfd_pkg::T_PRM))
    else $error("accepted request not started");

  // write pointer moves only when a result is loaded
  a_wp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sfd_pkg::T_LANE) |=> $stable(wp_q))
    else $error("write pointer moved without a result");
`endif

endmodule

`default_nettype wire
